FILE: hw/rtl/i2c_slave_transmitter_unit_macros.svh
// Assertion macros for the I2C slave transmitter RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef I2C_SLAVE_TRANSMITTER_UNIT_MACROS_SVH
`define I2C_SLAVE_TRANSMITTER_UNIT_MACROS_SVH

// Check a property on every rising edge once reset is released.
`define I2CST_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, during reset as well.
`define I2CST_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/i2cst_pkg.sv
// Shared types, codes and helpers for the I2C slave transmitter.
// No dependencies; imported by every module of the block.
package i2cst_pkg;

  // Register file layout
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_DATA = 2'd2;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'h3C;
  localparam logic [7:0] ON_CODE_RST    = 8'h02;

  localparam int unsigned REPLY_BYTES_DEF = 6;
  localparam int unsigned REPLY_BYTES_MAX = 6;

  // Event kinds
  localparam logic EVT_SDA_EDGE = 1'b0;
  localparam logic EVT_SCL_RISE = 1'b1;

  // Clock counter landmarks
  localparam int unsigned CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_ADDR_ACK = 7'd9;
  localparam logic [CNT_W-1:0] CNT_LAST     = 7'd63;

  typedef struct packed {
    logic event_kind;
    logic sda_level;
    logic scl_level;
  } in_item_t;

  typedef struct packed {
    logic sda_drive;
    logic sda_value;
    logic switch_on;
    logic busy_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] on_code;
  } addr_cfg_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } byte_slot_t;

  // Clocks that open a reply byte and which byte they load
  function automatic byte_slot_t byte_slot(input logic [CNT_W-1:0] cnt);
    byte_slot_t s;
    s.hit = 1'b1;
    case (cnt)
      7'd10: s.idx = 3'd0;
      7'd19: s.idx = 3'd1;
      7'd28: s.idx = 3'd2;
      7'd37: s.idx = 3'd3;
      7'd46: s.idx = 3'd4;
      7'd55: s.idx = 3'd5;
      default: begin
        s.hit = 1'b0;
        s.idx = 3'd0;
      end
    endcase
    return s;
  endfunction

endpackage

FILE: hw/rtl/i2cst_regs.sv
// Configuration registers of the I2C slave transmitter.
// Depends on i2cst_pkg.
module i2cst_regs #(
  parameter int unsigned REPLY_BYTES = i2cst_pkg::REPLY_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [i2cst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [i2cst_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output i2cst_pkg::addr_cfg_t                addr_cfg_o,
  output logic [REPLY_BYTES*8-1:0]            reply_o
);
  import i2cst_pkg::*;

  localparam int unsigned ReplyW = REPLY_BYTES * 8;

  logic [7:0]        slave_q;
  logic [7:0]        on_code_q;
  logic [ReplyW-1:0] reply_q;

  // Write the addressed register; keep only the bytes that are sent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q   <= SLAVE_ADDR_RST;
      on_code_q <= ON_CODE_RST;
      reply_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SLAVE_ADDR: slave_q   <= cfg_wdata_i[7:0];
        CFG_ON_CODE:    on_code_q <= cfg_wdata_i[7:0];
        CFG_REPLY_DATA: reply_q   <= cfg_wdata_i[CFG_DATA_W-1 -: ReplyW];
        default: ;
      endcase
    end
  end

  assign addr_cfg_o.slave_address = slave_q;
  assign addr_cfg_o.on_code       = on_code_q;
  assign reply_o                  = reply_q;

endmodule

FILE: hw/rtl/i2cst_fsm.sv
// Session state of the I2C slave transmitter: start, address, ack, reply bits.
// Depends on i2cst_pkg.
module i2cst_fsm #(
  parameter int unsigned REPLY_BYTES = i2cst_pkg::REPLY_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  i2cst_pkg::in_item_t          evt_i,
  input  i2cst_pkg::addr_cfg_t         addr_cfg_i,
  input  logic [REPLY_BYTES*8-1:0]     reply_i,
  output i2cst_pkg::out_item_t         res_o
);
  import i2cst_pkg::*;

  logic             active_q, active_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       tx_q, tx_d;
  logic             sda_out_q, sda_out_d;
  logic             drive_q, drive_d;
  logic             switch_q, switch_d;

  logic [CNT_W-1:0] cnt_inc;
  byte_slot_t       slot;
  logic [7:0]       reply_byte;

  assign cnt_inc = cnt_q + 7'd1;
  assign slot    = byte_slot(cnt_inc);

  // Pick the reply byte for this slot; bytes past the configured count are zero
  always_comb begin
    reply_byte = '0;
    for (int b = 0; b < REPLY_BYTES; b++) begin
      if (slot.idx == 3'(b)) begin
        reply_byte = reply_i[(REPLY_BYTES-1-b)*8 +: 8];
      end
    end
  end

  // Advance the session on one pin event
  always_comb begin
    active_d  = active_q;
    cnt_d     = cnt_q;
    addr_d    = addr_q;
    tx_d      = tx_q;
    sda_out_d = sda_out_q;
    drive_d   = drive_q;
    switch_d  = switch_q;
    if (!active_q) begin
      if (evt_i.event_kind == EVT_SDA_EDGE && !evt_i.sda_level && evt_i.scl_level) begin
        active_d = 1'b1;
      end
    end else if (evt_i.event_kind == EVT_SCL_RISE) begin
      cnt_d = cnt_inc;
      if (cnt_inc < CNT_ADDR_ACK) begin
        addr_d = {addr_q[6:0], evt_i.sda_level};
      end else if (cnt_inc == CNT_ADDR_ACK) begin
        drive_d   = 1'b1;
        sda_out_d = 1'b0;
        if (addr_q != addr_cfg_i.slave_address) begin
          // Foreign byte: steer the switch by the on code and drop the session
          switch_d = (addr_q == addr_cfg_i.on_code);
          active_d = 1'b0;
          cnt_d    = '0;
          addr_d   = '0;
          drive_d  = 1'b0;
        end
      end else if (cnt_inc > CNT_LAST) begin
        active_d = 1'b0;
        cnt_d    = '0;
        addr_d   = '0;
        drive_d  = 1'b0;
      end else if (slot.hit) begin
        sda_out_d = reply_byte[7];
        tx_d      = {reply_byte[6:0], 1'b0};
      end else begin
        // Shift out the next bit; ack slots see an empty register and send zero
        sda_out_d = tx_q[7];
        tx_d      = {tx_q[6:0], 1'b0};
      end
    end
  end

  // Hold session state between events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cnt_q     <= '0;
      addr_q    <= '0;
      tx_q      <= '0;
      sda_out_q <= 1'b0;
      drive_q   <= 1'b0;
      switch_q  <= 1'b1;
    end else if (step_i) begin
      active_q  <= active_d;
      cnt_q     <= cnt_d;
      addr_q    <= addr_d;
      tx_q      <= tx_d;
      sda_out_q <= sda_out_d;
      drive_q   <= drive_d;
      switch_q  <= switch_d;
    end
  end

  assign res_o.sda_drive = drive_d;
  assign res_o.sda_value = drive_d & sda_out_d;
  assign res_o.switch_on = switch_d;
  assign res_o.busy_res  = active_d;

endmodule

FILE: hw/rtl/i2c_slave_transmitter_unit.sv
// I2C slave transmitter: one pin event in, one line-drive result out per event.
// An accepted event sits in an input register; the session logic turns it into a
// result in the output register when that register is free or being taken, so one
// event is accepted every cycle while the output is not stalled. The path through
// the single session-update stage sets this rate. Configuration writes land at once;
// the user must make them only while no event is in flight (the block does not enforce it).
// Depends on i2cst_pkg, i2cst_regs, i2cst_fsm and the assertion macro header.
module i2c_slave_transmitter_unit #(
  parameter int unsigned REPLY_BYTES = i2cst_pkg::REPLY_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  i2cst_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output i2cst_pkg::out_item_t              out_data_o,
  input  logic                              cfg_we_i,
  input  logic [i2cst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [i2cst_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import i2cst_pkg::*;
  `include "i2c_slave_transmitter_unit_macros.svh"

  logic                     in_vld_q;
  in_item_t                 in_q;
  logic                     out_vld_q;
  out_item_t                out_q;
  logic                     advance;
  addr_cfg_t                addr_cfg;
  logic [REPLY_BYTES*8-1:0] reply;
  out_item_t                res;

  // Move the held event into the result register when that slot frees up
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  i2cst_regs #(.REPLY_BYTES(REPLY_BYTES)) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .addr_cfg_o (addr_cfg),
    .reply_o    (reply)
  );

  i2cst_fsm #(.REPLY_BYTES(REPLY_BYTES)) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .evt_i     (in_q),
    .addr_cfg_i(addr_cfg),
    .reply_i   (reply),
    .res_o     (res)
  );

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // Capture the event on each transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `I2CST_ASSERT(a_value_needs_drive, clk_i, rst_ni, out_vld_q |-> (!out_q.sda_value || out_q.sda_drive), "driven level shown while SDA released")
  `I2CST_ASSERT(a_drive_needs_busy, clk_i, rst_ni, (out_vld_q && out_q.sda_drive) |-> out_q.busy_res, "SDA driven outside a session")
  `I2CST_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i), "input stalled without a full pipeline")
  `I2CST_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!in_vld_q && !out_vld_q), "pipeline not empty after reset")

endmodule

FILE: dv/i2cst_checker.sv
// Scoreboard for the I2C slave transmitter: watches the event, result and register ports.
// Predicts the line drive for every accepted pin event and compares it with the result stream.
// Depends on i2cst_pkg.
`timescale 1ns / 100ps
module i2cst_checker
  import i2cst_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_item_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_item_t            out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                   fail_cnt_o,
  output int                   backlog_o,
  output int                   checked_o
);

  // Eight data clocks plus one acknowledge clock per byte
  localparam int BYTE_FRAME = 9;

  // Register copies
  logic [7:0]  own_addr;
  logic [7:0]  on_addr;
  logic [47:0] reply_word;

  // Bus session state
  logic       in_session;
  logic [6:0] clk_cnt;
  logic [7:0] addr_sr;
  logic [7:0] tx_sr;
  logic       bit_q;
  logic       drive_q;
  logic       switch_q;

  out_item_t pending_lines[$];
  int        mismatches = 0;
  int        backlog    = 0;
  int        compared   = 0;

  assign fail_cnt_o = mismatches;
  assign backlog_o  = backlog;
  assign checked_o  = compared;

  // Release the line and go back to watching for a start
  function automatic void close_session();
    in_session = 1'b0;
    clk_cnt    = '0;
    addr_sr    = '0;
    drive_q    = 1'b0;
  endfunction

  // Advance the session by one pin event and return the resulting line state
  function automatic out_item_t predict_line(in_item_t ev);
    out_item_t res;
    int        slot;
    if (!in_session) begin
      if (ev.event_kind == EVT_SDA_EDGE && !ev.sda_level && ev.scl_level) in_session = 1'b1;
    end else if (ev.event_kind == EVT_SCL_RISE) begin
      clk_cnt = clk_cnt + 7'd1;
      if (clk_cnt < CNT_ADDR_ACK) begin
        addr_sr = {addr_sr[6:0], ev.sda_level};
      end else if (clk_cnt == CNT_ADDR_ACK) begin
        drive_q = 1'b1;
        bit_q   = 1'b0;
        // Foreign byte: steer the switch and drop the session
        if (addr_sr != own_addr) begin
          switch_q = (addr_sr == on_addr);
          close_session();
        end
      end else if (clk_cnt > CNT_LAST) begin
        close_session();
      end else begin
        // Load the next reply byte at the first clock of its frame
        if (int'(clk_cnt) % BYTE_FRAME == 1) begin
          slot  = int'(clk_cnt) / BYTE_FRAME - 1;
          tx_sr = (slot < int'(REPLY_BYTES_DEF)) ? reply_word[47 - 8*slot -: 8] : 8'h00;
        end
        bit_q = tx_sr[7];
        tx_sr = {tx_sr[6:0], 1'b0};
      end
    end
    res.sda_drive = drive_q;
    res.sda_value = drive_q & bit_q;
    res.switch_on = switch_q;
    res.busy_res  = in_session;
    return res;
  endfunction

  task automatic check_bit(input string field, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %b, got %b", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      own_addr   = SLAVE_ADDR_RST;
      on_addr    = ON_CODE_RST;
      reply_word = '0;
      in_session = 1'b0;
      clk_cnt    = '0;
      addr_sr    = '0;
      tx_sr      = '0;
      bit_q      = 1'b0;
      drive_q    = 1'b0;
      switch_q   = 1'b1;
      pending_lines.delete();
    end else begin
      // Compare an outgoing transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_lines.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %b, expected nothing", $time, out_data_i);
        end else begin
          want = pending_lines.pop_front();
          compared++;
          check_bit("sda_drive", want.sda_drive, out_data_i.sda_drive);
          check_bit("sda_value", want.sda_value, out_data_i.sda_value);
          check_bit("switch_on", want.switch_on, out_data_i.switch_on);
          check_bit("busy_res",  want.busy_res,  out_data_i.busy_res);
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLAVE_ADDR: own_addr   = cfg_wdata_i[7:0];
          CFG_ON_CODE:    on_addr    = cfg_wdata_i[7:0];
          CFG_REPLY_DATA: reply_word = cfg_wdata_i[47:0];
          default: ;
        endcase
      end
      // Predict the result of an incoming transfer
      if (in_valid_i && in_ready_i) pending_lines.push_back(predict_line(in_data_i));
    end
    backlog = pending_lines.size();
  end

endmodule

FILE: dv/tb_top.sv
// Top of the I2C slave transmitter testbench: clock, reset, pin-event stimulus and verdict.
// Depends on i2cst_pkg, i2c_slave_transmitter_unit and i2cst_checker.
`timescale 1ns / 100ps
module tb_top;
  import i2cst_pkg::*;

  localparam int ITEM_TARGET = 1200;
  localparam int PHASE_ITEMS = 150;
  localparam int IDLE_LIMIT  = 2000;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_SLAVE_ADDR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_cnt;
  int backlog;
  int checked;

  // Stimulus bookkeeping
  logic       calm = 1'b0;
  logic [7:0] cur_addr = SLAVE_ADDR_RST;
  logic [7:0] cur_on   = ON_CODE_RST;
  int         items_sent   = 0;
  int         sessions     = 0;
  int         full_replies = 0;
  int         settings     = 0;
  int         stall_left   = 0;
  int         quiet_cycles = 0;

  i2c_slave_transmitter_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  i2cst_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .backlog_o   (backlog),
    .checked_o   (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("i2c_slave_transmitter_unit verification failed");
      $finish;
    end
  end

  // Offer one pin event, optionally after an idle burst, and hold it until the transfer
  task automatic send_event(input logic kind, input logic sda, input logic scl);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{event_kind: kind, sda_level: sda, scl_level: scl};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Start condition, address byte, acknowledge clock and, on a match, the reply clocks
  task automatic run_session(input logic [7:0] addr, input bit loose);
    int   stop_at;
    logic bit_val;
    logic scl_val;
    stop_at = 64;
    if (loose && $urandom_range(0, 9) == 0) stop_at = $urandom_range(1, 63);
    send_event(EVT_SDA_EDGE, 1'b0, 1'b1);
    for (int n = 1; n <= stop_at; n++) begin
      if (n > 9 && addr != cur_addr) break;
      // Stray SDA transitions inside the session
      if (loose && $urandom_range(0, 11) == 0) begin
        send_event(EVT_SDA_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      bit_val = (n <= 8) ? addr[8 - n] : 1'($urandom_range(0, 1));
      scl_val = (loose && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1;
      send_event(EVT_SCL_RISE, bit_val, scl_val);
    end
    sessions++;
    if (addr == cur_addr && stop_at == 64) full_replies++;
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic drain_lines();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (backlog != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] addr, input logic [7:0] on,
                          input logic [47:0] reply);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SLAVE_ADDR;
    cfg_wdata <= {40'd0, addr};
    @(posedge clk_i);
    cfg_idx   <= CFG_ON_CODE;
    cfg_wdata <= {40'd0, on};
    @(posedge clk_i);
    cfg_idx   <= CFG_REPLY_DATA;
    cfg_wdata <= reply;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_addr  = addr;
    cur_on    = on;
    settings++;
  endtask

  function automatic logic [47:0] rand_reply();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  initial begin
    int         phase;
    int         phase_end;
    logic [7:0] addr;
    phase = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle SCL rises, idle SDA transitions that are no start, then two foreign bytes
    send_event(EVT_SCL_RISE, 1'b1, 1'b1);
    send_event(EVT_SCL_RISE, 1'b0, 1'b0);
    send_event(EVT_SDA_EDGE, 1'b1, 1'b1);
    send_event(EVT_SDA_EDGE, 1'b0, 1'b0);
    send_event(EVT_SDA_EDGE, 1'b1, 1'b0);
    // The second start edge lands inside the session and must be ignored
    send_event(EVT_SDA_EDGE, 1'b0, 1'b1);
    run_session(8'h00, 1'b0);
    run_session(ON_CODE_RST, 1'b0);

    // Random phases, each under a new register setting
    while (items_sent < ITEM_TARGET) begin
      drain_lines();
      case (phase)
        0:       set_regs(SLAVE_ADDR_RST, ON_CODE_RST, {48{1'b1}});
        1:       set_regs(8'h00, 8'hFF, '0);
        2:       set_regs(8'hFF, 8'h00, rand_reply());
        default: set_regs(8'($urandom), 8'($urandom), rand_reply());
      endcase
      phase++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        calm = (items_sent > ITEM_TARGET * 85 / 100);
        if ($urandom_range(0, 6) == 0) begin
          // Noise: any event, start conditions included
          repeat ($urandom_range(1, 6)) begin
            send_event(1'($urandom), 1'($urandom), 1'($urandom));
          end
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: addr = cur_addr;
            4, 5:       addr = cur_on;
            6, 7:       addr = 8'($urandom);
            default:    addr = cur_addr ^ (8'd1 << $urandom_range(0, 7));
          endcase
          run_session(addr, 1'b1);
        end
        if (!calm && $urandom_range(0, 19) == 0) drain_lines();
      end
    end

    calm = 1'b1;
    drain_lines();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("Sent %0d pin events in %0d bus sessions (%0d complete replies) under %0d settings;",
             items_sent, sessions, full_replies, settings);
    $display("compared %0d line results against prediction.", checked);
    if (fail_cnt == 0 && backlog == 0) begin
      $display("i2c_slave_transmitter_unit verification clean");
    end else begin
      $display("i2c_slave_transmitter_unit verification failed");
    end
    $finish;
  end

endmodule
